>>> sv/cpfa_pkg.sv
// Package for the contiguous page frame allocator: commands, status codes,
// frame states and the command and result structs. No dependencies.
`default_nettype none
package cpfa_pkg;

  typedef enum logic [2:0] {
    CMD_KALLOC = 3'd0,
    CMD_UALLOC = 3'd1,
    CMD_UPAGE  = 3'd2,
    CMD_KFREE  = 3'd3,
    CMD_OFREE  = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_FND  = 2'd2
  } status_code_t;

  localparam logic [1:0] FS_FREE  = 2'd0;
  localparam logic [1:0] FS_FIXED = 2'd1;
  localparam logic [1:0] FS_DIRTY = 2'd2;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;
  localparam logic [CfgIdxW-1:0] REG_RESERVED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IN_USE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RAM_BASE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_KWINDOW  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [9:0]  page_count;
    logic [7:0]  owner;
    logic [19:0] virt_page;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] phys_page;
    logic [9:0]  frames_changed;
  } result_item_t;

endpackage
`default_nettype wire

>>> sv/contiguous_page_frame_allocator_unit.sv
// Top level of the contiguous page frame allocator: frame map memory and
// its scan sequencer. Depends on cpfa_pkg.
//
//  channel  | signals                        | transfer when
//  ---------+--------------------------------+----------------------------
//  command  | start, busy, cmd_in            | start && !busy
//  result   | done, result                   | done (one cycle, no stall)
//  config   | cfg_we, cfg_index, cfg_data    | cfg_we
//
// After reset a clearing pass writes every map entry, one per cycle,
// with busy high. An allocation scans from reserved_frames upward,
// reading each frame and then deciding on it (S_RD, then S_EVAL), then
// writes the run back at one frame per cycle. A kernel free reads and
// decides on each frame to find the head, then clears the run, writing
// each frame in S_FREE and reading the next one in S_FRD. An owner free
// reads, decides and rewrites each frame below the limit (S_RD, S_EVAL,
// S_FREE). The single-port frame map sets this pacing. Results cannot be
// stalled; busy stays high until the result cycle is over.
`default_nettype none
module contiguous_page_frame_allocator_unit #(
  parameter int unsigned FRAME_COUNT = 512
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire  cpfa_pkg::cmd_item_t    cmd_in,
  output logic                         done,
  output cpfa_pkg::result_item_t       result,
  input  wire                          cfg_we,
  input  wire  [cpfa_pkg::CfgIdxW-1:0] cfg_index,
  input  wire  [cpfa_pkg::CfgDataW-1:0] cfg_data
);
  import cpfa_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_COUNT);
  localparam int unsigned CW = AW + 1;   // counter holds FRAME_COUNT itself
  localparam int unsigned EW = 2 + 8 + 20 + 10;

  typedef struct packed {
    logic [1:0]  st;
    logic [7:0]  own;
    logic [19:0] tag;
    logic [9:0]  len;
  } entry_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_FILL  = 8'b0001_0000,
    S_FREE  = 8'b0010_0000,
    S_FRD   = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  // frame map, one synchronous port
  logic [EW-1:0] map_mem [FRAME_COUNT];
  entry_t        rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wd;
    end
    rd_q <= map_mem[mem_addr];
  end

  // configuration
  logic [9:0]  reserved_frames, frames_in_use;
  logic [19:0] ram_base_page, kernel_window_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_frames    <= '0;
      frames_in_use      <= 10'd512;
      ram_base_page      <= '0;
      kernel_window_page <= 20'd524288;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESERVED: reserved_frames    <= cfg_data[9:0];
        REG_IN_USE:   frames_in_use      <= cfg_data[9:0];
        REG_RAM_BASE: ram_base_page      <= cfg_data;
        REG_KWINDOW:  kernel_window_page <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan limit: frames present, cut at the map depth
  logic [CW-1:0] limit;
  always_comb begin
    if ({3'b0, frames_in_use} > 13'(FRAME_COUNT)) begin
      limit = CW'(FRAME_COUNT);
    end else begin
      limit = CW'(frames_in_use);
    end
  end

  state_t        state;
  cmd_item_t     c;
  logic [CW-1:0] idx;       // current frame
  logic [CW-1:0] run;       // free frames seen in a row, or frames left
  logic [CW-1:0] head;      // run head
  logic [CW-1:0] need;      // frames requested
  logic [10:0]   changed;   // frames changed; the result field saturates at 1023
  logic [1:0]    r_status;
  logic [19:0]   r_phys;
  logic [19:0]   head_win;

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);
  assign result.status = r_status;
  assign result.phys_page = r_phys;
  assign result.frames_changed = changed[10] ? 10'h3FF : changed[9:0];

  logic [CW-1:0] run_inc;
  assign run_inc = run + CW'(1);

  logic [19:0] own_win;
  assign own_win = kernel_window_page + ram_base_page + 20'(idx);

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = idx[AW-1:0];
    mem_wd   = '0;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_FILL: begin
        mem_we = 1'b1;
        mem_wd.st  = (c.cmd == CMD_KALLOC) ? FS_FIXED : FS_DIRTY;
        mem_wd.own = c.owner;
        mem_wd.len = (idx == head) ? 10'(need) : 10'd0;
        case (c.cmd)
          CMD_KALLOC: mem_wd.tag = head_win;
          CMD_UALLOC: mem_wd.tag = own_win;
          default:    mem_wd.tag = c.virt_page;
        endcase
      end
      // clear a frame once its old contents have been read; an owner free clears only the owner's live frames
      S_FREE: mem_we = (c.cmd == CMD_OFREE) ?
                       (rd_q.st != FS_FREE && rd_q.own == c.owner) : 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      idx     <= '0;
      changed <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (idx == CW'(FRAME_COUNT - 1)) begin
            state <= S_IDLE;
          end
          idx <= idx + CW'(1);
        end
        S_IDLE: begin
          if (start) begin
            c        <= cmd_in;
            changed  <= '0;
            run      <= '0;
            r_phys   <= '0;
            r_status <= ST_NOT_FND;
            need     <= (cmd_in.cmd == CMD_UPAGE) ? CW'(1) : CW'(cmd_in.page_count);
            if (cmd_in.cmd == CMD_OFREE) begin
              idx   <= '0;
              state <= (limit == '0) ? S_RESP : S_RD;
              r_status <= ST_DONE;
            end else if (cmd_in.cmd > CMD_OFREE) begin
              state <= S_RESP;
            end else begin
              idx <= CW'(reserved_frames);
              if (cmd_in.cmd <= CMD_UPAGE) begin
                r_status <= ST_NO_SPACE;
                // drop a zero count, and one that no run below the limit can hold
                if (cmd_in.cmd != CMD_UPAGE && (cmd_in.page_count == '0 ||
                    {1'b0, cmd_in.page_count} > 11'(limit))) begin
                  state <= S_RESP;
                end else begin
                  state <= ({1'b0, reserved_frames} >= 11'(limit)) ? S_RESP : S_RD;
                end
              end else begin
                state <= ({1'b0, reserved_frames} >= 11'(limit)) ? S_RESP : S_RD;
              end
            end
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          // decide on the frame just read
          case (c.cmd)
            CMD_OFREE: begin
              state <= S_FREE;
            end
            CMD_KFREE: begin
              if (rd_q.st != FS_FREE && rd_q.tag == c.virt_page) begin
                head     <= idx;
                run      <= CW'(rd_q.len);
                r_status <= ST_DONE;
                state    <= (rd_q.len == '0) ? S_RESP : S_FREE;
              end else if (idx + CW'(1) >= limit) begin
                state <= S_RESP;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            default: begin
              if (rd_q.st == FS_FREE && run_inc == need) begin
                head     <= idx + CW'(1) - need;
                idx      <= idx + CW'(1) - need;
                head_win <= kernel_window_page + ram_base_page + 20'(idx + CW'(1) - need);
                r_phys   <= ram_base_page + 20'(idx + CW'(1) - need);
                r_status <= ST_DONE;
                changed  <= 11'(need);
                state    <= S_FILL;
              end else begin
                run <= (rd_q.st == FS_FREE) ? run_inc : '0;
                if (idx + CW'(1) >= limit) begin
                  state <= S_RESP;
                end else begin
                  idx   <= idx + CW'(1);
                  state <= S_RD;
                end
              end
            end
          endcase
        end
        S_FILL: begin
          if (idx + CW'(1) == head + need) begin
            state <= S_RESP;
          end
          idx <= idx + CW'(1);
        end
        S_FREE: begin
          if (c.cmd == CMD_OFREE) begin
            if (mem_we) changed <= changed + 11'd1;
            if (idx + CW'(1) >= limit) begin
              state <= S_RESP;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_RD;
            end
          end else begin
            // kernel free: rd_q holds the frame at idx; count, clear, go on
            if (rd_q.st != FS_FREE) changed <= changed + 11'd1;
            if (run == CW'(1) || idx + CW'(1) >= limit) begin
              state <= S_RESP;
            end else begin
              run   <= run - CW'(1);
              idx   <= idx + CW'(1);
              state <= S_FRD;
            end
          end
        end
        S_FRD: state <= S_FREE;   // wait for the next frame's read
        S_RESP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/cpfa_checker.sv
// Port-level checker for the contiguous page frame allocator, bound to the
// top level. Depends on cpfa_pkg.
`default_nettype none
module cpfa_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        start,
  input wire                        busy,
  input wire                        done,
  input wire cpfa_pkg::result_item_t result
);
  import cpfa_pkg::*;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_DONE || result.status == ST_NO_SPACE ||
              result.status == ST_NOT_FND))
    else $error("bad status");
  a_phys: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_DONE) |-> (result.phys_page == '0 &&
                                             result.frames_changed == '0))
    else $error("failed command reports payload");
endmodule

bind contiguous_page_frame_allocator_unit cpfa_checker u_cpfa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .result(result)
);
`default_nettype wire

>>> dv/contiguous_page_frame_allocator_unit_tb.sv
// Self-checking testbench for the contiguous page frame allocator unit.
// Holds a frame-map predictor in a scoreboard class; depends on cpfa_pkg.
module contiguous_page_frame_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpfa_pkg::*;

  localparam int unsigned FRAMES = 512;
  localparam int unsigned N_RANDOM = 1150;
  localparam longint unsigned CYCLE_LIMIT = 64'd6000000;

  // Frame map mirror and register copy; predicts one result per command.
  class frame_map_board;
    logic [1:0]  st[FRAMES];
    logic [7:0]  own[FRAMES];
    logic [19:0] tag[FRAMES];
    logic [9:0]  len[FRAMES];
    logic [9:0]  rsv, in_use;
    logic [19:0] ram_base, kwin;
    result_item_t pending[$];
    int errors;
    int n_done, n_nospace, n_notfound;

    function new();
      foreach (st[i]) begin
        st[i] = FS_FREE; own[i] = 0; tag[i] = 0; len[i] = 0;
      end
      rsv = 0; in_use = 10'd512; ram_base = 0; kwin = 20'd524288;
      errors = 0;
      n_done = 0; n_nospace = 0; n_notfound = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        REG_RESERVED: rsv = val[9:0];
        REG_IN_USE:   in_use = val[9:0];
        REG_RAM_BASE: ram_base = val;
        REG_KWINDOW:  kwin = val;
        default: ;
      endcase
    endfunction

    function void free_frame(int i);
      st[i] = FS_FREE; own[i] = 0; tag[i] = 0; len[i] = 0;
    endfunction

    // Note an accepted command: update the mirror and queue its result.
    function void note_command(cmd_item_t c);
      result_item_t r;
      int lim, n, run, head, cnt;
      bit hit;
      r = '{status: ST_NOT_FND, phys_page: 0, frames_changed: 0};
      lim = (in_use > FRAMES) ? FRAMES : in_use;
      cnt = 0;
      if (c.cmd <= CMD_UPAGE) begin
        n = (c.cmd == CMD_UPAGE) ? 1 : c.page_count;
        hit = 0; run = 0; head = 0;
        if (n != 0) begin
          for (int i = rsv; i < lim && !hit; i++) begin
            if (st[i] == FS_FREE) begin
              run++;
              if (run == n) begin
                hit = 1; head = i + 1 - n;
              end
            end else run = 0;
          end
        end
        if (!hit) r.status = ST_NO_SPACE;
        else begin
          for (int k = 0; k < n; k++) begin
            own[head+k] = c.owner;
            len[head+k] = (k == 0) ? n[9:0] : 10'd0;
            st[head+k] = (c.cmd == CMD_KALLOC) ? FS_FIXED : FS_DIRTY;
            case (c.cmd)
              CMD_KALLOC: tag[head+k] = kwin + ram_base + head[19:0];
              CMD_UALLOC: tag[head+k] = kwin + ram_base + 20'(head + k);
              default:    tag[head+k] = c.virt_page;
            endcase
          end
          r.status = ST_DONE;
          r.phys_page = ram_base + head[19:0];
          r.frames_changed = n[9:0];
        end
      end else if (c.cmd == CMD_KFREE) begin
        hit = 0; head = 0;
        for (int i = rsv; i < lim && !hit; i++)
          if (st[i] != FS_FREE && tag[i] == c.virt_page) begin
            hit = 1; head = i;
          end
        if (hit) begin
          n = len[head];
          for (int k = 0; k < n && head + k < lim; k++) begin
            if (st[head+k] != FS_FREE) cnt++;
            free_frame(head + k);
          end
          r.status = ST_DONE;
          r.frames_changed = cnt[9:0];
        end
      end else if (c.cmd == CMD_OFREE) begin
        for (int i = 0; i < lim; i++)
          if (st[i] != FS_FREE && own[i] == c.owner) begin
            free_frame(i); cnt++;
          end
        r.status = ST_DONE;
        r.frames_changed = cnt[9:0];
      end
      case (r.status)
        ST_DONE:     n_done++;
        ST_NO_SPACE: n_nospace++;
        default:     n_notfound++;
      endcase
      pending.push_back(r);
    endfunction

    // Check one result transfer against the oldest expectation.
    function void check_result(result_item_t got);
      result_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.phys_page !== want.phys_page) begin
        $display("%0t: phys_page expected %h actual %h", $time, want.phys_page,
                 got.phys_page);
        errors++;
      end
      if (got.frames_changed !== want.frames_changed) begin
        $display("%0t: frames_changed expected %0d actual %0d", $time,
                 want.frames_changed, got.frames_changed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  cmd_item_t cmd_in = '0;
  logic done;
  result_item_t result;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  frame_map_board board = new();
  longint unsigned cycles = 0;
  int n_sent = 0;

  always #5 clk = ~clk;

  contiguous_page_frame_allocator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Sample results at the rising edge; they cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive one command: idle a random gap, raise start, hold until transfer.
  // Step to the next falling edge first so start is never driven twice at once.
  task automatic send_command(cmd_item_t c);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(negedge clk);
    cmd_in <= c;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.note_command(c);
    n_sent++;
    @(negedge clk);
    start <= 1'b0;
    cmd_in <= '0;
  endtask

  // Wait for all expectations to drain, then allow the worst scan to finish.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_item_t make_cmd(logic [2:0] op, int cnt, int who, int vp);
    cmd_item_t c;
    c.cmd = op;
    c.page_count = cnt[9:0];
    c.owner = who[7:0];
    c.virt_page = vp[19:0];
    return c;
  endfunction

  // Mostly well-formed traffic: small allocations, frees of mapped tags,
  // occasional large requests, illegal opcodes and raw noise.
  task automatic random_phase(int items);
    cmd_item_t c;
    int pick, idx;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      c = make_cmd(CMD_KALLOC, $urandom_range(1, 12), $urandom_range(0, 7),
                   $urandom);
      if (pick < 25) c.cmd = CMD_KALLOC;
      else if (pick < 45) c.cmd = CMD_UALLOC;
      else if (pick < 62) c.cmd = CMD_UPAGE;
      else if (pick < 82) begin
        c.cmd = CMD_KFREE;
        // Aim at a tag from the map mirror most of the time.
        idx = $urandom_range(0, FRAMES - 1);
        if ($urandom_range(0, 4) != 0) c.virt_page = board.tag[idx];
      end else if (pick < 90) c.cmd = CMD_OFREE;
      else if (pick < 94) c.page_count = 10'($urandom_range(0, 1023));
      else if (pick < 97) c.cmd = 3'($urandom_range(5, 7));
      else c = cmd_item_t'(41'({$urandom, $urandom}));
      if (c.cmd == CMD_UPAGE && $urandom_range(0, 1))
        c.virt_page = 20'($urandom_range(0, 31));
      send_command(c);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // Wait out the clearing pass.
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed: field extremes, every command and the special cases.
    send_command(make_cmd(CMD_KALLOC, 0, 1, 0));            // zero count
    send_command(make_cmd(CMD_KALLOC, 3, 255, 20'hFFFFF));
    send_command(make_cmd(CMD_UALLOC, 2, 0, 0));
    send_command(make_cmd(CMD_UPAGE, 0, 7, 20'hFFFFF));
    send_command(make_cmd(CMD_UPAGE, 1023, 7, 20'hABCDE));
    send_command(make_cmd(CMD_KFREE, 0, 0, 20'h80000));     // head of kernel run
    send_command(make_cmd(CMD_KFREE, 0, 0, 20'h12345));     // tag not present
    send_command(make_cmd(CMD_OFREE, 0, 0, 0));             // owner zero
    send_command(make_cmd(CMD_OFREE, 0, 7, 0));
    send_command(make_cmd(CMD_OFREE, 0, 200, 0));           // owns nothing
    send_command(make_cmd(CMD_UALLOC, 513, 3, 0));          // larger than map
    send_command(make_cmd(CMD_KALLOC, 512, 9, 0));          // whole map
    send_command(make_cmd(CMD_UPAGE, 0, 9, 5));             // full: no space
    send_command(make_cmd(CMD_OFREE, 0, 9, 0));             // 512 freed
    send_command(make_cmd(3'd5, 1023, 255, 20'hFFFFF));
    send_command(make_cmd(3'd7, 0, 0, 0));
    send_command(make_cmd(CMD_UALLOC, 1023, 255, 20'hFFFFF));
    drain();

    // Extreme registers: tiny window with wrapping page arithmetic.
    write_reg(REG_RESERVED, 20'd510);
    write_reg(REG_IN_USE, 20'd1023);                        // clipped to map size
    write_reg(REG_RAM_BASE, 20'hFFFFF);
    write_reg(REG_KWINDOW, 20'hFFFFF);
    send_command(make_cmd(CMD_KALLOC, 2, 4, 0));
    send_command(make_cmd(CMD_UALLOC, 1, 4, 0));
    send_command(make_cmd(CMD_KFREE, 0, 0, 20'h001FC));
    send_command(make_cmd(CMD_OFREE, 0, 4, 0));
    drain();

    // Cut run: free a run partly beyond a shrunken limit.
    write_reg(REG_RESERVED, 20'd0);
    write_reg(REG_IN_USE, 20'd512);
    write_reg(REG_RAM_BASE, 20'd0);
    write_reg(REG_KWINDOW, 20'd0);
    send_command(make_cmd(CMD_OFREE, 0, 0, 0));
    send_command(make_cmd(CMD_KALLOC, 8, 2, 0));
    drain();
    write_reg(REG_IN_USE, 20'd4);
    send_command(make_cmd(CMD_KFREE, 0, 0, 0));
    drain();

    // Random phases across several register settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_RESERVED, 20'd0); write_reg(REG_IN_USE, 20'd512);
          write_reg(REG_RAM_BASE, 20'h00100); write_reg(REG_KWINDOW, 20'h80000);
        end
        1: begin
          write_reg(REG_RESERVED, 20'd16); write_reg(REG_IN_USE, 20'd64);
        end
        2: begin
          write_reg(REG_RESERVED, 20'd512); write_reg(REG_IN_USE, 20'd1);
        end
        3: begin
          write_reg(REG_RESERVED, 20'd4); write_reg(REG_IN_USE, 20'd40);
          write_reg(REG_RAM_BASE, 20'($urandom)); write_reg(REG_KWINDOW, 20'($urandom));
        end
        default: begin
          write_reg(REG_RESERVED, 20'd0); write_reg(REG_IN_USE, 20'd512);
        end
      endcase
      random_phase((ph == 2) ? 30 : N_RANDOM / 4);
      drain();
    end

    $display("Sent %0d commands: %0d done, %0d no_space, %0d not_found predicted.",
             n_sent, board.n_done, board.n_nospace, board.n_notfound);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
